### rtl/hts_pkg.sv
// Shared types, constants and jamo lookup tables for the Hangul two-set composer.
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

  // Jamo are held as a 6-bit offset from JAMO_BASE; offset zero means empty.
  localparam logic [15:0] JAMO_BASE    = 16'h3130;
  localparam logic [15:0] SYL_BASE     = 16'hAC00;
  localparam logic [20:0] CONS_LO      = 21'h3131;
  localparam logic [20:0] CONS_HI      = 21'h314E;
  localparam logic [20:0] VOW_LO       = 21'h314F;
  localparam logic [20:0] VOW_HI       = 21'h3163;
  localparam logic [5:0]  VOW_LO_OFF   = 6'h1F;
  localparam logic [4:0]  MEDIAL_COUNT = 5'd21;
  localparam logic [4:0]  FINAL_COUNT  = 5'd28;

  localparam int CP_W   = 21;
  localparam int JAMO_W = 6;
  localparam int IDX_W  = 5;
  localparam int ACC_W  = 16;

  // Kind of the flush that an item causes
  localparam logic [1:0] FK_NONE = 2'd0;
  localparam logic [1:0] FK_JAMO = 2'd1;
  localparam logic [1:0] FK_SYL  = 2'd2;

  typedef logic [JAMO_W-1:0] jamo_t;

  // What one accepted item asks the sequencer to emit
  typedef struct packed {
    logic [1:0]       kind;   // FK_*
    jamo_t            jamo;   // lone jamo to emit for FK_JAMO
    logic [IDX_W-1:0] ii;     // initial index for FK_SYL
    logic [IDX_W-1:0] mu;     // medial index for FK_SYL
    logic [IDX_W-1:0] fidx;   // final index for FK_SYL
    logic             pass;   // code point follows the flush
  } dec_t;

  // {found, index}
  function automatic logic [IDX_W:0] init_idx(input jamo_t c);
    logic [IDX_W:0] r;
    case (c)
      6'h01: r = {1'b1, 5'd0};
      6'h02: r = {1'b1, 5'd1};
      6'h04: r = {1'b1, 5'd2};
      6'h07: r = {1'b1, 5'd3};
      6'h08: r = {1'b1, 5'd4};
      6'h09: r = {1'b1, 5'd5};
      6'h11: r = {1'b1, 5'd6};
      6'h12: r = {1'b1, 5'd7};
      6'h13: r = {1'b1, 5'd8};
      6'h15: r = {1'b1, 5'd9};
      6'h16: r = {1'b1, 5'd10};
      6'h17: r = {1'b1, 5'd11};
      6'h18: r = {1'b1, 5'd12};
      6'h19: r = {1'b1, 5'd13};
      6'h1A: r = {1'b1, 5'd14};
      6'h1B: r = {1'b1, 5'd15};
      6'h1C: r = {1'b1, 5'd16};
      6'h1D: r = {1'b1, 5'd17};
      6'h1E: r = {1'b1, 5'd18};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Zero when the jamo is not a final
  function automatic logic [IDX_W-1:0] fin_idx(input jamo_t c);
    logic [IDX_W-1:0] r;
    case (c)
      6'h01: r = 5'd1;
      6'h02: r = 5'd2;
      6'h03: r = 5'd3;
      6'h04: r = 5'd4;
      6'h05: r = 5'd5;
      6'h06: r = 5'd6;
      6'h07: r = 5'd7;
      6'h09: r = 5'd8;
      6'h0A: r = 5'd9;
      6'h0B: r = 5'd10;
      6'h0C: r = 5'd11;
      6'h0D: r = 5'd12;
      6'h0E: r = 5'd13;
      6'h0F: r = 5'd14;
      6'h10: r = 5'd15;
      6'h11: r = 5'd16;
      6'h12: r = 5'd17;
      6'h14: r = 5'd18;
      6'h15: r = 5'd19;
      6'h16: r = 5'd20;
      6'h17: r = 5'd21;
      6'h18: r = 5'd22;
      6'h1A: r = 5'd23;
      6'h1B: r = 5'd24;
      6'h1C: r = 5'd25;
      6'h1D: r = 5'd26;
      6'h1E: r = 5'd27;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic jamo_t join_med(input jamo_t x, input jamo_t y);
    jamo_t r;
    case ({x, y})
      {6'h27, 6'h1F}: r = 6'h28;
      {6'h27, 6'h20}: r = 6'h29;
      {6'h27, 6'h33}: r = 6'h2A;
      {6'h2C, 6'h23}: r = 6'h2D;
      {6'h2C, 6'h24}: r = 6'h2E;
      {6'h2C, 6'h33}: r = 6'h2F;
      {6'h31, 6'h33}: r = 6'h32;
      default:        r = '0;
    endcase
    return r;
  endfunction

  function automatic jamo_t join_fin(input jamo_t x, input jamo_t y);
    jamo_t r;
    case ({x, y})
      {6'h01, 6'h15}: r = 6'h03;
      {6'h04, 6'h18}: r = 6'h05;
      {6'h04, 6'h1E}: r = 6'h06;
      {6'h09, 6'h01}: r = 6'h0A;
      {6'h09, 6'h11}: r = 6'h0B;
      {6'h09, 6'h12}: r = 6'h0C;
      {6'h09, 6'h15}: r = 6'h0D;
      {6'h09, 6'h1C}: r = 6'h0E;
      {6'h09, 6'h1D}: r = 6'h0F;
      {6'h09, 6'h1E}: r = 6'h10;
      {6'h12, 6'h15}: r = 6'h14;
      default:        r = '0;
    endcase
    return r;
  endfunction

  // {found, first half, second half}
  function automatic logic [2*JAMO_W:0] split_fin(input jamo_t c);
    logic [2*JAMO_W:0] r;
    case (c)
      6'h03: r = {1'b1, 6'h01, 6'h15};
      6'h05: r = {1'b1, 6'h04, 6'h18};
      6'h06: r = {1'b1, 6'h04, 6'h1E};
      6'h0A: r = {1'b1, 6'h09, 6'h01};
      6'h0B: r = {1'b1, 6'h09, 6'h11};
      6'h0C: r = {1'b1, 6'h09, 6'h12};
      6'h0D: r = {1'b1, 6'h09, 6'h15};
      6'h0E: r = {1'b1, 6'h09, 6'h1C};
      6'h0F: r = {1'b1, 6'h09, 6'h1D};
      6'h10: r = {1'b1, 6'h09, 6'h1E};
      6'h14: r = {1'b1, 6'h12, 6'h15};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/hts_mac.sv
// Shared multiply-add unit: acc <= a * k + b, one step per enabled cycle.
`timescale 1ns / 1ps
`default_nettype none

module hts_mac (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [8:0]               a,
  input  wire logic [hts_pkg::IDX_W-1:0] k,
  input  wire logic [hts_pkg::ACC_W-1:0] b,
  output logic      [hts_pkg::ACC_W-1:0] acc
);

  logic [13:0] prod;

  assign prod = 14'(a) * 14'(k);

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= hts_pkg::ACC_W'({2'b00, prod} + b);
    end
  end

endmodule

`default_nettype wire

### rtl/hts_pending.sv
// Pending syllable registers and the per-item composition decision.
`timescale 1ns / 1ps
`default_nettype none

module hts_pending (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic                      req_type,
  input  wire logic [hts_pkg::CP_W-1:0]  code_point,
  output hts_pkg::dec_t                  dec
);

  hts_pkg::jamo_t pend_i, pend_m, pend_f;
  hts_pkg::jamo_t pend_i_next, pend_m_next, pend_f_next;

  always_comb begin
    hts_pkg::jamo_t            c;
    hts_pkg::jamo_t            fl_i, fl_m, fl_f;
    hts_pkg::jamo_t            jf, jm;
    logic [hts_pkg::IDX_W:0]   ci, fi;
    logic [2*hts_pkg::JAMO_W:0] sp;
    logic                      is_cons, is_vow, do_flush, pass;

    c       = hts_pkg::JAMO_W'(code_point - 21'(hts_pkg::JAMO_BASE));
    ci      = hts_pkg::init_idx(c);
    is_cons = (code_point >= hts_pkg::CONS_LO) && (code_point <= hts_pkg::CONS_HI) && ci[5];
    is_vow  = (code_point >= hts_pkg::VOW_LO) && (code_point <= hts_pkg::VOW_HI);
    jf      = '0;
    jm      = '0;
    sp      = hts_pkg::split_fin(pend_f);

    fl_i = pend_i;
    fl_m = pend_m;
    fl_f = pend_f;
    do_flush = 1'b0;
    pass     = 1'b0;
    pend_i_next = pend_i;
    pend_m_next = pend_m;
    pend_f_next = pend_f;

    if (req_type) begin
      do_flush = 1'b1;
      pend_i_next = '0; pend_m_next = '0; pend_f_next = '0;
    end else if (is_cons) begin
      if (pend_m != '0) begin
        jf = hts_pkg::join_fin(pend_f, c);
        if (pend_i == '0) begin
          do_flush = 1'b1;
        end else if (pend_f == '0) begin
          if (hts_pkg::fin_idx(c) != '0) begin
            pend_f_next = c;
          end else begin
            do_flush = 1'b1;
          end
        end else if (jf != '0) begin
          pend_f_next = jf;
        end else begin
          do_flush = 1'b1;
        end
      end else if (pend_i == '0 && pend_f == '0) begin
        pend_i_next = c;
      end else if (pend_i != '0) begin
        jf = hts_pkg::join_fin(pend_i, c);
        if (jf != '0) begin
          pend_f_next = jf;
          pend_i_next = '0;
        end else begin
          do_flush = 1'b1;
        end
      end else begin
        do_flush = 1'b1;
      end
      if (do_flush) begin
        pend_i_next = c; pend_m_next = '0; pend_f_next = '0;
      end
    end else if (is_vow) begin
      if (pend_m == '0) begin
        if (pend_f != '0) begin
          do_flush = 1'b1;
          if (sp[12]) begin
            // compound final splits: first half goes out alone
            fl_i = sp[11:6]; fl_m = '0; fl_f = '0;
            pend_i_next = sp[5:0];
          end else begin
            pend_i_next = '0;
          end
        end
        pend_m_next = c;
        pend_f_next = '0;
      end else if (pend_f == '0) begin
        jm = hts_pkg::join_med(pend_m, c);
        if (jm != '0) begin
          pend_m_next = jm;
        end else begin
          do_flush = 1'b1;
          pend_i_next = '0; pend_m_next = c;
        end
      end else begin
        do_flush = 1'b1;
        if (sp[12]) begin
          fl_f = sp[11:6];
          pend_i_next = sp[5:0];
        end else begin
          // lone final moves over to start the next syllable
          fl_f = '0;
          pend_i_next = pend_f;
        end
        pend_m_next = c;
        pend_f_next = '0;
      end
    end else begin
      do_flush = 1'b1;
      pass     = 1'b1;
      pend_i_next = '0; pend_m_next = '0; pend_f_next = '0;
    end

    fi       = hts_pkg::init_idx(fl_i);
    dec.pass = pass;
    dec.ii   = fi[4:0];
    dec.mu   = hts_pkg::IDX_W'(fl_m - hts_pkg::VOW_LO_OFF);
    dec.fidx = hts_pkg::fin_idx(fl_f);
    dec.jamo = (fl_i != '0) ? fl_i : (fl_m != '0) ? fl_m : fl_f;
    if (!do_flush || (fl_i == '0 && fl_m == '0 && fl_f == '0)) begin
      dec.kind = hts_pkg::FK_NONE;
    end else if (fl_i != '0 && fl_m != '0) begin
      dec.kind = hts_pkg::FK_SYL;
    end else begin
      dec.kind = hts_pkg::FK_JAMO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_i <= '0;
      pend_m <= '0;
      pend_f <= '0;
    end else if (take) begin
      pend_i <= pend_i_next;
      pend_m <= pend_m_next;
      pend_f <= pend_f_next;
    end
  end

endmodule

`default_nettype wire

### rtl/hangul_two_set_composer_unit.sv
// Top level of the Hangul two-set composer: sequencer, shared unit and output register.
//
//  channel  dir  beat contents
//  s_*      in   tdata: code_point[20:0]; tuser: req_type (1 = end of text)
//  m_*      out  tdata: out_code_point[20:0]; tlast: last result of the item
//
// An item is accepted and then emits 0..2 results; when a syllable is
// composed, (I*21+M) then *28+F+base first run through the one multiply-add
// unit, in states MUL1 and MUL2.
// rst (synchronous) empties the pending syllable and the output register.
// A stalled m_tready holds the sequencer in its emit state; s_tready is high
// only when the sequencer is idle, and the last result may still wait then.
`timescale 1ns / 1ps
`default_nettype none

module hangul_two_set_composer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
  input  wire logic        s_tuser,   // [0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [20:0] out_code_point, [23:21] zero
  output logic             m_tlast
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_MUL2  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_PASS  = 3'd4;

  logic [2:0]     state, state_next;
  hts_pkg::dec_t  dec, dec_q;
  logic [20:0]    cp_q;
  logic           take, out_free;
  logic           mac_en;
  logic [8:0]     mac_a;
  logic [hts_pkg::IDX_W-1:0] mac_k;
  logic [hts_pkg::ACC_W-1:0] mac_b, acc;
  logic [hts_pkg::ACC_W-1:0] flush_val;

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  hts_pending u_pending (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .req_type   (s_tuser),
    .code_point (s_tdata[20:0]),
    .dec        (dec)
  );

  always_comb begin
    mac_en = 1'b0;
    mac_a  = '0;
    mac_k  = hts_pkg::MEDIAL_COUNT;
    mac_b  = '0;
    case (state)
      ST_MUL1: begin
        mac_en = 1'b1;
        mac_a  = 9'(dec_q.ii);
        mac_k  = hts_pkg::MEDIAL_COUNT;
        mac_b  = hts_pkg::ACC_W'(dec_q.mu);
      end
      ST_MUL2: begin
        mac_en = 1'b1;
        mac_a  = acc[8:0];
        mac_k  = hts_pkg::FINAL_COUNT;
        mac_b  = hts_pkg::SYL_BASE + hts_pkg::ACC_W'(dec_q.fidx);
      end
      default: begin
      end
    endcase
  end

  hts_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .k   (mac_k),
    .b   (mac_b),
    .acc (acc)
  );

  assign flush_val = (dec_q.kind == hts_pkg::FK_SYL) ? acc
                   : hts_pkg::JAMO_BASE + hts_pkg::ACC_W'(dec_q.jamo);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (dec.kind)
            hts_pkg::FK_SYL:  state_next = ST_MUL1;
            hts_pkg::FK_JAMO: state_next = ST_FLUSH;
            default:          state_next = dec.pass ? ST_PASS : ST_IDLE;
          endcase
        end
      end
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_FLUSH;
      ST_FLUSH: if (out_free) state_next = dec_q.pass ? ST_PASS : ST_IDLE;
      ST_PASS:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_FLUSH || state == ST_PASS) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dec_q <= dec;
      cp_q  <= s_tdata[20:0];
    end
    if (state == ST_FLUSH && out_free) begin
      m_tdata <= {8'h00, flush_val};
      m_tlast <= !dec_q.pass;
    end else if (state == ST_PASS && out_free) begin
      m_tdata <= {3'b000, cp_q};
      m_tlast <= 1'b1;
    end
  end

endmodule

`default_nettype wire
